// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset disable.
`define BMQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bmq check failed");

// Assertion held regardless of reset.
`define BMQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bmq check failed");

`endif

// ----- design/bmq_pkg.sv -----
`default_nettype none

package bmq_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int RESET_CAP     = 16;
    localparam int CAP_W         = 7;
    localparam int WORD_W        = 32;
    localparam int MSG_WORDS     = 4;
    localparam int MSG_W         = WORD_W * MSG_WORDS;
    localparam int OP_W          = 2;
    localparam int OUT_DATA_W    = 136;

    typedef enum logic [OP_W-1:0] {
        OP_SEND   = 2'd0,
        OP_URGENT = 2'd1,
        OP_RECV   = 2'd2,
        OP_PEEK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- design/bmq_ctrl.sv -----
`default_nettype none

module bmq_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  bmq_pkg::t_dp_status   i_status,
    output bmq_pkg::t_ctrl_cmd    o_cmd
);

    bmq_pkg::t_state r_state;
    bmq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bmq_pkg::ST_EXEC;
                end
            end
            bmq_pkg::ST_EXEC: begin
                n_state = bmq_pkg::ST_RESULT;
            end
            bmq_pkg::ST_RESULT: begin
                if (!i_status.out_busy) begin
                    n_state = bmq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bmq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            bmq_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            bmq_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            bmq_pkg::ST_RESULT: begin
                o_cmd.load_out = !i_status.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/bmq_dp.sv -----
`default_nettype none

module bmq_dp #(
    parameter int MAX_SLOTS = bmq_pkg::MAX_SLOTS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  bmq_pkg::t_ctrl_cmd                 i_cmd,
    output bmq_pkg::t_dp_status                o_status,
    input  wire  [bmq_pkg::OP_W-1:0]           i_op,
    input  wire  [bmq_pkg::MSG_W-1:0]          i_msg,
    input  wire                                i_cfg_wen,
    input  wire  [bmq_pkg::CAP_W-1:0]          i_cfg_wdata,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_out_ok,
    output logic [bmq_pkg::MSG_W-1:0]          o_out_msg,
    output logic [bmq_pkg::CAP_W-1:0]          o_out_fill
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = bmq_pkg::CAP_W;
    localparam int AW = ((IW > CW) ? IW : CW) + 1;
    localparam logic [AW-1:0] CAP_MAX = AW'(MAX_SLOTS);
    localparam int CAP_RST_I =
        (bmq_pkg::RESET_CAP > MAX_SLOTS) ? MAX_SLOTS : bmq_pkg::RESET_CAP;
    localparam logic [CW-1:0] CAP_RST = CW'(CAP_RST_I);

    logic [bmq_pkg::MSG_W-1:0] mem [MAX_SLOTS];

    bmq_pkg::t_op              r_op;
    logic [bmq_pkg::MSG_W-1:0] r_msg;
    logic [CW-1:0]             r_cap;
    logic [IW-1:0]             r_head;
    logic [CW-1:0]             r_count;
    logic [bmq_pkg::MSG_W-1:0] r_rdata;
    logic                      r_ok;
    logic                      r_is_read;
    logic [CW-1:0]             r_fill;
    logic                      r_out_valid;
    logic                      r_out_ok;
    logic [bmq_pkg::MSG_W-1:0] r_out_msg;
    logic [CW-1:0]             r_out_fill;

    logic [IW-1:0] n_head;
    logic [CW-1:0] n_count;
    logic          n_ok;
    logic          n_is_read;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          rd_en;
    logic          full;
    logic          empty;
    logic [AW-1:0] head_ext;
    logic [AW-1:0] cap_ext;
    logic [AW-1:0] tail_sum;
    logic [AW-1:0] inc_sum;
    logic [IW-1:0] tail;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [AW-1:0] cfg_ext;
    logic [CW-1:0] cfg_cap;

    assign full     = (r_count == r_cap);
    assign empty    = (r_count == '0);
    assign head_ext = AW'(r_head);
    assign cap_ext  = AW'(r_cap);
    assign tail_sum = head_ext + AW'(r_count);
    assign tail     = (tail_sum >= cap_ext) ? IW'(tail_sum - cap_ext) : IW'(tail_sum);
    assign head_dec = (r_head == '0) ? IW'(cap_ext - AW'(1)) : r_head - IW'(1);
    assign inc_sum  = head_ext + AW'(1);
    assign head_inc = (inc_sum >= cap_ext) ? '0 : IW'(inc_sum);
    assign cfg_ext  = AW'(i_cfg_wdata);
    assign cfg_cap  = (cfg_ext > CAP_MAX) ? CW'(CAP_MAX) : i_cfg_wdata;

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_ok      = 1'b0;
        n_is_read = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = tail;
        rd_en     = 1'b0;
        unique case (r_op)
            bmq_pkg::OP_SEND: begin
                if (!full) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            bmq_pkg::OP_URGENT: begin
                wr_addr = head_dec;
                if (!full) begin
                    wr_en   = 1'b1;
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            bmq_pkg::OP_RECV: begin
                if (!empty) begin
                    rd_en     = 1'b1;
                    n_head    = head_inc;
                    n_count   = r_count - CW'(1);
                    n_ok      = 1'b1;
                    n_is_read = 1'b1;
                end
            end
            bmq_pkg::OP_PEEK: begin
                if (!empty) begin
                    rd_en     = 1'b1;
                    n_ok      = 1'b1;
                    n_is_read = 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_msg;
        end
        if (i_cmd.exec && rd_en) begin
            r_rdata <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= bmq_pkg::t_op'(i_op);
            r_msg <= i_msg;
        end
        if (i_cmd.exec) begin
            r_ok      <= n_ok;
            r_is_read <= n_is_read;
            r_fill    <= n_count;
        end
        if (i_cmd.load_out) begin
            r_out_ok   <= r_ok;
            r_out_msg  <= r_is_read ? r_rdata : '0;
            r_out_fill <= r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RST;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen && (i_cfg_wdata != '0)) begin
                r_cap   <= cfg_cap;
                r_head  <= '0;
                r_count <= '0;
            end else if (i_cmd.exec) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_ok          = r_out_ok;
    assign o_out_msg         = r_out_msg;
    assign o_out_fill        = r_out_fill;

endmodule

`default_nettype wire

// ----- design/bounded_message_queue_top.sv -----
// Bounded ring queue of four-word messages. Each request word carries an
// operation in tuser (send to tail, priority send to head, receive, peek)
// and a message in tdata; each request yields exactly one result word with
// a success flag, the received or peeked message (zero otherwise) and the
// fill level after the request. Requests are handled one at a time: a
// request is taken, executed against the slot RAM on the next cycle, and
// its result is then loaded into the output register once that register
// is free; the message comes from the registered read of the single-port
// slot RAM. A stalled result holds the queue until taken. A non-zero
// capacity write empties the queue; capacities above MAX_SLOTS saturate,
// zero is ignored. Write capacity only when idle.
`default_nettype none

module bounded_message_queue_top #(
    parameter int MAX_SLOTS = bmq_pkg::MAX_SLOTS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // msg_word0, msg_word1, msg_word2, msg_word3
    input  wire  [bmq_pkg::MSG_W-1:0]          s_axis_tdata,
    // op
    input  wire  [bmq_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // out_word0, out_word1, out_word2, out_word3, fill_level, zero pad
    output logic [bmq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // ok
    output logic                               m_axis_tuser,
    input  wire                                i_cfg_wen,
    input  wire  [bmq_pkg::CAP_W-1:0]          i_cfg_wdata
);

    bmq_pkg::t_ctrl_cmd  cmd;
    bmq_pkg::t_dp_status status;

    logic [bmq_pkg::MSG_W-1:0] out_msg;
    logic [bmq_pkg::CAP_W-1:0] out_fill;

    bmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bmq_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (s_axis_tuser),
        .i_msg       (s_axis_tdata),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_ok    (m_axis_tuser),
        .o_out_msg   (out_msg),
        .o_out_fill  (out_fill)
    );

    assign m_axis_tdata = {
        {(bmq_pkg::OUT_DATA_W - bmq_pkg::MSG_W - bmq_pkg::CAP_W){1'b0}},
        out_fill,
        out_msg
    };

endmodule

`default_nettype wire

// ----- design/bmq_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module bmq_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [bmq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input wire                                m_axis_tuser
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // one request in flight
    `BMQ_ASSERT(a_one_at_a_time, i_clk, i_rst_n, in_acc |=> !s_axis_tready)

    // every request produces a result word
    `BMQ_ASSERT(a_result_follows, i_clk, i_rst_n, in_acc |-> ##3 m_axis_tvalid)

    // failed requests return no message
    `BMQ_ASSERT(a_fail_zero, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[bmq_pkg::MSG_W-1:0] == '0))

    // stalled result holds
    `BMQ_ASSERT(a_out_hold, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind bounded_message_queue_top bmq_checker u_bmq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- dv/bounded_message_queue_top_test.sv -----
`timescale 1ns / 1ps

module bounded_message_queue_top_test;

    import bmq_pkg::*;

    localparam int SLOTS      = MAX_SLOTS_DEF;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic               ok;
        logic [MSG_W-1:0]   msg;
        logic [CAP_W-1:0]   fill;
    } t_queue_result;

    class message_queue_scoreboard;
        logic [MSG_W-1:0] slots [SLOTS];
        int               head;
        int               held;
        int               capacity;
        t_queue_result    pending_results [$];
        int               mismatches;

        function new();
            head       = 0;
            held       = 0;
            capacity   = RESET_CAP;
            mismatches = 0;
        endfunction

        function void write_capacity(logic [CAP_W-1:0] value);
            if (value == 0)
                return;
            capacity = (value > SLOTS) ? SLOTS : int'(value);
            head     = 0;
            held     = 0;
        endfunction

        function void note_request(t_op op, logic [MSG_W-1:0] msg);
            t_queue_result r;
            int            slot;
            r.ok  = 1'b0;
            r.msg = '0;
            if (op == OP_SEND || op == OP_URGENT) begin
                if (held < capacity) begin
                    if (op == OP_URGENT) begin
                        head = (head == 0) ? capacity - 1 : head - 1;
                        slot = head;
                    end else begin
                        slot = head + held;
                        if (slot >= capacity)
                            slot -= capacity;
                    end
                    slots[slot] = msg;
                    held++;
                    r.ok = 1'b1;
                end
            end else if (held > 0) begin
                r.msg = slots[head];
                if (op == OP_RECV) begin
                    head = (head + 1 >= capacity) ? 0 : head + 1;
                    held--;
                end
                r.ok = 1'b1;
            end
            r.fill = CAP_W'(held);
            pending_results.push_back(r);
        endfunction

        function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
        endfunction

        function void check_result(logic ok, logic [OUT_DATA_W-1:0] data);
            t_queue_result exp_r;
            int            w;
            if (pending_results.size() == 0) begin
                flag("unexpected word", 32'd0, data[31:0]);
                return;
            end
            exp_r = pending_results.pop_front();
            if (ok !== exp_r.ok)
                flag("ok", 32'(exp_r.ok), 32'(ok));
            for (w = 0; w < MSG_WORDS; w++)
                if (data[w*WORD_W +: WORD_W] !== exp_r.msg[w*WORD_W +: WORD_W])
                    flag($sformatf("out_word%0d", w), exp_r.msg[w*WORD_W +: WORD_W],
                         data[w*WORD_W +: WORD_W]);
            if (data[MSG_W +: CAP_W] !== exp_r.fill)
                flag("fill_level", 32'(exp_r.fill), 32'(data[MSG_W +: CAP_W]));
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [MSG_W-1:0]        s_axis_tdata;
    logic [OP_W-1:0]         s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    i_cfg_wen;
    logic [CAP_W-1:0]        i_cfg_wdata;

    message_queue_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;

    bounded_message_queue_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MSG_W-1:0] rand_msg();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    task automatic drive_request(t_op op, logic [MSG_W-1:0] msg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= msg;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_request(op, msg);
    endtask

    task automatic drain_queue();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        drain_queue();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        sb.write_capacity(value);
        @(posedge i_clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    // bias per chunk: 0 fill, 1 drain, 2 mixed
    task automatic random_batch(int n);
        int  i;
        int  bias;
        int  roll;
        t_op op;
        bias = 2;
        for (i = 0; i < n; i++) begin
            if (i % 16 == 0)
                bias = $urandom_range(2);
            roll = $urandom_range(99);
            case (bias)
                0:       op = (roll < 80) ? OP_SEND : OP_RECV;
                1:       op = (roll < 80) ? OP_RECV : OP_SEND;
                default: op = (roll < 50) ? OP_SEND : OP_RECV;
            endcase
            if (op == OP_SEND && $urandom_range(3) == 0)
                op = OP_URGENT;
            else if (op == OP_RECV && $urandom_range(3) == 0)
                op = OP_PEEK;
            drive_request(op, rand_msg());
        end
    endtask

    initial begin
        logic [CAP_W-1:0] caps [10];
        int               b;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_SEND;
        i_cfg_wen     <= 1'b0;
        i_cfg_wdata   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        set_idling(0);
        drive_request(OP_PEEK, '1);
        drive_request(OP_RECV, '1);
        drive_request(OP_SEND, '0);
        drive_request(OP_SEND, '1);
        drive_request(OP_URGENT, rand_msg());
        drive_request(OP_PEEK, '0);
        drive_request(OP_RECV, '0);
        // zero capacity is ignored, contents stay
        write_capacity(7'd0);
        drive_request(OP_PEEK, rand_msg());
        drive_request(OP_RECV, rand_msg());
        drive_request(OP_RECV, rand_msg());
        drive_request(OP_RECV, rand_msg());
        write_capacity(7'd1);
        drive_request(OP_SEND, rand_msg());
        drive_request(OP_SEND, rand_msg());
        drive_request(OP_URGENT, rand_msg());
        drive_request(OP_PEEK, rand_msg());
        drive_request(OP_RECV, rand_msg());
        drive_request(OP_URGENT, rand_msg());
        drive_request(OP_RECV, rand_msg());
        write_capacity(7'd127);
        drive_request(OP_SEND, rand_msg());
        drive_request(OP_URGENT, rand_msg());
        drive_request(OP_PEEK, rand_msg());

        caps[0] = 7'd16;
        caps[1] = 7'd3;
        caps[2] = 7'd64;
        caps[3] = 7'd127;
        caps[4] = 7'd0;
        caps[5] = 7'd1;
        caps[6] = 7'd2;
        caps[7] = CAP_W'($urandom_range(SLOTS, 1));
        caps[8] = CAP_W'($urandom_range(127, SLOTS + 1));
        caps[9] = 7'd5;
        for (b = 0; b < 10; b++) begin
            write_capacity(caps[b]);
            set_idling(b % 4);
            random_batch(78);
        end

        drain_queue();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/bmq_pkg.sv
design/bmq_ctrl.sv
design/bmq_dp.sv
design/bounded_message_queue_top.sv
design/bmq_checker.sv
dv/bounded_message_queue_top_test.sv
